// ===== hw/rtl/stag_pkg.sv =====
// Shared constants and register codes for the strided tensor address generator.
`default_nettype none

package stag_pkg;

  // Widths fixed by the register map and the beat fields
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned DIM_COUNT_W = 3;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned INDEX_W     = 32;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_DIMS_DEF     = 4;
  localparam int unsigned EXTENT_WIDTH_DEF = 16;
  localparam int unsigned ADDR_WIDTH_DEF   = 32;

  // Register reset values
  localparam logic [DIM_COUNT_W-1:0] DIM_COUNT_RST = DIM_COUNT_W'(1);
  localparam logic [CFG_DATA_W-1:0]  EXTENTS_RST   = 64'h0001_0001_0001_0001;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIM_COUNT   = 3'd0,
    REG_BASE_OFFSET = 3'd1,
    REG_EXTENTS     = 3'd2,
    REG_STRIDES     = 3'd3,
    REG_FILL_MODE   = 3'd4,
    REG_FILL_VALUE  = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/stag_walk.sv =====
// Odometer walk: per-dimension counters, element index and the first pipeline stage.
`default_nettype none

module stag_walk #(
  parameter int unsigned MAX_DIMS     = stag_pkg::MAX_DIMS_DEF,
  parameter int unsigned EXTENT_WIDTH = stag_pkg::EXTENT_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // live configuration
  input  wire logic [stag_pkg::DIM_COUNT_W-1:0]      dim_count_i,
  input  wire logic [stag_pkg::CFG_DATA_W-1:0]       extents_i,
  input  wire logic                                  fill_mode_i,
  input  wire logic [stag_pkg::WORD_W-1:0]           fill_value_i,
  // input beat
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [stag_pkg::WORD_W-1:0]           element_value_i,
  input  wire logic                                  restart_i,
  // stage one beat
  output logic                                       s1_valid_o,
  input  wire logic                                  s1_stall_i,
  output logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0]      s1_cnt_o,
  output logic [stag_pkg::INDEX_W-1:0]               s1_index_o,
  output logic [stag_pkg::WORD_W-1:0]                s1_value_o,
  output logic                                       s1_last_o
);
  import stag_pkg::*;

  localparam int unsigned CMP_W = DIM_COUNT_W + 1;

  logic [EXTENT_WIDTH-1:0] cnt_q   [MAX_DIMS];
  logic [EXTENT_WIDTH-1:0] cnt_d   [MAX_DIMS];
  logic [EXTENT_WIDTH-1:0] cnt_cur [MAX_DIMS];
  logic [EXTENT_WIDTH-1:0] cnt_adv [MAX_DIMS];
  logic [EXTENT_WIDTH-1:0] ext     [MAX_DIMS];
  logic [EXTENT_WIDTH-1:0] ext_m1  [MAX_DIMS];
  logic [MAX_DIMS-1:0]     active;
  logic [MAX_DIMS-1:0]     act_next;
  logic [INDEX_W-1:0]      idx_q, idx_d, idx_cur;
  logic                    last;
  logic [MAX_DIMS:0]       carry;
  logic [EXTENT_WIDTH-1:0] lane_sum [MAX_DIMS];
  logic                    accept;

  logic                    s1_valid_q, s1_valid_d;
  logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0] s1_cnt_q;
  logic [INDEX_W-1:0]      s1_index_q;
  logic [WORD_W-1:0]       s1_value_q;
  logic                    s1_last_q;

  // Decode lane extents and which lanes take part in the walk
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
    logic [EXTENT_WIDTH-1:0] ext_raw;
    assign ext_raw   = EXTENT_WIDTH'(extents_i >> (g * EXTENT_WIDTH));
    assign ext[g]    = (ext_raw == '0) ? EXTENT_WIDTH'(1) : ext_raw;
    assign ext_m1[g] = ext[g] - EXTENT_WIDTH'(1);
    assign active[g] = (g == 0) || (CMP_W'(g) < {1'b0, dim_count_i});
    if (g + 1 < MAX_DIMS) begin : g_nxt
      assign act_next[g] = (CMP_W'(g + 1) < {1'b0, dim_count_i});
    end else begin : g_top
      assign act_next[g] = 1'b0;
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && s1_stall_i;

  // Apply restart, test for the last element and advance the odometer
  always_comb begin
    last     = 1'b1;
    carry[0] = 1'b1;
    idx_cur  = restart_i ? '0 : idx_q;
    for (int i = 0; i < MAX_DIMS; i++) begin
      cnt_cur[i] = restart_i ? '0 : cnt_q[i];
      if (active[i] && (cnt_cur[i] < ext_m1[i])) begin
        last = 1'b0;
      end
      lane_sum[i]  = cnt_cur[i] + EXTENT_WIDTH'(carry[i]);
      carry[i+1]   = carry[i] && act_next[i] && (lane_sum[i] >= ext[i]);
      cnt_adv[i]   = carry[i+1] ? '0 : lane_sum[i];
    end
    // Clear every lane after the last element, else take the advanced count
    for (int i = 0; i < MAX_DIMS; i++) begin
      cnt_d[i] = cnt_q[i];
      if (accept) begin
        cnt_d[i] = last ? '0 : cnt_adv[i];
      end
    end
    idx_d = idx_q;
    if (accept) begin
      idx_d = last ? '0 : idx_cur + INDEX_W'(1);
    end
  end

  // Hold or load stage one
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (!s1_stall_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cnt_q[i] <= '0;
      end
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      idx_q      <= idx_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        s1_cnt_q[i] <= active[i] ? cnt_cur[i] : '0;
      end
      s1_index_q <= idx_cur;
      s1_value_q <= fill_mode_i ? fill_value_i : element_value_i;
      s1_last_q  <= last;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_cnt_o   = s1_cnt_q;
  assign s1_index_o = s1_index_q;
  assign s1_value_o = s1_value_q;
  assign s1_last_o  = s1_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/stag_addr.sv =====
// Address datapath: per-lane stride products, then offset plus product sum into the output register.
`default_nettype none

module stag_addr #(
  parameter int unsigned MAX_DIMS     = stag_pkg::MAX_DIMS_DEF,
  parameter int unsigned EXTENT_WIDTH = stag_pkg::EXTENT_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH   = stag_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // live configuration
  input  wire logic [stag_pkg::WORD_W-1:0]           base_offset_i,
  input  wire logic [stag_pkg::CFG_DATA_W-1:0]       strides_i,
  // stage one beat
  input  wire logic                                  s1_valid_i,
  output logic                                       s1_stall_o,
  input  wire logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0] s1_cnt_i,
  input  wire logic [stag_pkg::INDEX_W-1:0]          s1_index_i,
  input  wire logic [stag_pkg::WORD_W-1:0]           s1_value_i,
  input  wire logic                                  s1_last_i,
  // result beat
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [ADDR_WIDTH-1:0]                      target_address_o,
  output logic [stag_pkg::INDEX_W-1:0]               linear_index_o,
  output logic [stag_pkg::WORD_W-1:0]                value_out_o,
  output logic                                       last_element_o
);
  import stag_pkg::*;

  localparam int unsigned PROD_W = 2 * EXTENT_WIDTH;

  logic [EXTENT_WIDTH-1:0] stride [MAX_DIMS];
  logic                    s2_valid_q, s2_valid_d, s2_ready, s3_ready;
  logic [PROD_W-1:0]       s2_prod_q [MAX_DIMS];
  logic [INDEX_W-1:0]      s2_index_q;
  logic [WORD_W-1:0]       s2_value_q;
  logic                    s2_last_q;
  logic                    out_valid_q, out_valid_d;
  logic [ADDR_WIDTH-1:0]   addr_sum;
  logic [ADDR_WIDTH-1:0]   addr_q;
  logic [INDEX_W-1:0]      index_q;
  logic [WORD_W-1:0]       value_q;
  logic                    last_q;
  logic                    s1_move, s2_move;

  // Lanes past the packed word read stride zero
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_stride
    assign stride[g] = EXTENT_WIDTH'(strides_i >> (g * EXTENT_WIDTH));
  end

  // Stage ready chain
  assign s3_ready   = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_stall_o = !s2_ready;
  assign s1_move    = s1_valid_i && s2_ready;
  assign s2_move    = s2_valid_q && s3_ready;

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_move) begin
      s2_valid_d = 1'b1;
    end else if (s3_ready) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Sum the offset and the lane products modulo the address width
  always_comb begin
    addr_sum = ADDR_WIDTH'(base_offset_i);
    for (int i = 0; i < MAX_DIMS; i++) begin
      addr_sum = addr_sum + ADDR_WIDTH'(s2_prod_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Register one product per lane
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        s2_prod_q[i] <= PROD_W'(s1_cnt_i[i]) * PROD_W'(stride[i]);
      end
      s2_index_q <= s1_index_i;
      s2_value_q <= s1_value_i;
      s2_last_q  <= s1_last_i;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      addr_q  <= addr_sum;
      index_q <= s2_index_q;
      value_q <= s2_value_q;
      last_q  <= s2_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign target_address_o = addr_q;
  assign linear_index_o   = index_q;
  assign value_out_o      = value_q;
  assign last_element_o   = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/strided_tensor_address_generator.sv =====
// Top level: configuration registers, odometer walk and address pipeline.
`default_nettype none

// Walks an n-dimensional strided view in row-major order, one element per input
// beat, and returns one result beat per input beat: base_offset plus the sum of
// counter times stride (modulo 2^ADDR_WIDTH), the compact row-major index, the
// pass-through or fill value, and a flag on the last element, after which the
// walk wraps to the start. restart set on a beat begins the walk anew at that
// beat. The block takes one beat per cycle while the result channel does not
// stall; each beat passes, in order, the counter update and snapshot, the
// registered stride products and the final sum into the output register. Up to
// three beats are in flight, so input is taken while a finished result still
// waits on a stalled output. Configuration must be written by the user only while
// the block is idle; the block itself does not enforce this.
module strided_tensor_address_generator #(
  parameter int unsigned MAX_DIMS     = stag_pkg::MAX_DIMS_DEF,
  parameter int unsigned EXTENT_WIDTH = stag_pkg::EXTENT_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH   = stag_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [stag_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [stag_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [stag_pkg::WORD_W-1:0]         element_value_i,
  input  wire logic                                restart_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [ADDR_WIDTH-1:0]                    target_address_o,
  output logic [stag_pkg::INDEX_W-1:0]             linear_index_o,
  output logic [stag_pkg::WORD_W-1:0]              value_out_o,
  output logic                                     last_element_o
);
  import stag_pkg::*;

  logic [DIM_COUNT_W-1:0] dim_count_q;
  logic [WORD_W-1:0]      base_offset_q;
  logic [CFG_DATA_W-1:0]  extents_q;
  logic [CFG_DATA_W-1:0]  strides_q;
  logic                   fill_mode_q;
  logic [WORD_W-1:0]      fill_value_q;

  logic                                 s1_valid, s1_stall;
  logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0] s1_cnt;
  logic [INDEX_W-1:0]                   s1_index;
  logic [WORD_W-1:0]                    s1_value;
  logic                                 s1_last;

  // Write configuration registers, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q   <= DIM_COUNT_RST;
      base_offset_q <= '0;
      extents_q     <= EXTENTS_RST;
      strides_q     <= '0;
      fill_mode_q   <= 1'b0;
      fill_value_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DIM_COUNT:   dim_count_q   <= cfg_data_i[DIM_COUNT_W-1:0];
        REG_BASE_OFFSET: base_offset_q <= cfg_data_i[WORD_W-1:0];
        REG_EXTENTS:     extents_q     <= cfg_data_i;
        REG_STRIDES:     strides_q     <= cfg_data_i;
        REG_FILL_MODE:   fill_mode_q   <= cfg_data_i[0];
        REG_FILL_VALUE:  fill_value_q  <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  stag_walk #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_WIDTH(EXTENT_WIDTH)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dim_count_i    (dim_count_q),
    .extents_i      (extents_q),
    .fill_mode_i    (fill_mode_q),
    .fill_value_i   (fill_value_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .restart_i      (restart_i),
    .s1_valid_o     (s1_valid),
    .s1_stall_i     (s1_stall),
    .s1_cnt_o       (s1_cnt),
    .s1_index_o     (s1_index),
    .s1_value_o     (s1_value),
    .s1_last_o      (s1_last)
  );

  stag_addr #(
    .MAX_DIMS    (MAX_DIMS),
    .EXTENT_WIDTH(EXTENT_WIDTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_addr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .base_offset_i   (base_offset_q),
    .strides_i       (strides_q),
    .s1_valid_i      (s1_valid),
    .s1_stall_o      (s1_stall),
    .s1_cnt_i        (s1_cnt),
    .s1_index_i      (s1_index),
    .s1_value_i      (s1_value),
    .s1_last_i       (s1_last),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .target_address_o(target_address_o),
    .linear_index_o  (linear_index_o),
    .value_out_o     (value_out_o),
    .last_element_o  (last_element_o)
  );

  // Input backs up only behind a result beat that the sink is stalling
  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result beat");

  // A restart beat enters stage one at index zero
  a_restart_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && restart_i) |=> (s1_valid && (s1_index == '0)))
    else $error("restart beat did not start at index zero");

  // Hold a stalled result beat unchanged
  a_stalled_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(target_address_o)))
    else $error("stalled result beat changed or dropped");

endmodule

`default_nettype wire

// ===== dv/strided_tensor_address_generator_test.sv =====
// Self-checking testbench for the strided tensor address generator.
module strided_tensor_address_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stag_pkg::*;

  localparam int unsigned NUM_LANES   = MAX_DIMS_DEF;
  localparam int unsigned LANE_W      = EXTENT_WIDTH_DEF;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned SHOWN_ERRS  = 10;

  // Indexes past the register map; writes to them must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] index;
    logic [31:0] data;
    logic        last;
  } walk_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [WORD_W-1:0]      element_value_i;
  logic                   restart_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [31:0]            target_address_o;
  logic [INDEX_W-1:0]     linear_index_o;
  logic [WORD_W-1:0]      value_out_o;
  logic                   last_element_o;

  // Shadow registers and walk state of the address generator
  logic [DIM_COUNT_W-1:0] dim_count_q;
  logic [31:0]            base_offset_q;
  logic [63:0]            extents_q;
  logic [63:0]            strides_q;
  logic                   fill_mode_q;
  logic [31:0]            fill_value_q;
  logic [LANE_W-1:0]      walk_ctr [NUM_LANES];
  logic [31:0]            walk_index;

  walk_result_t pending_elements [$];
  int unsigned  mismatches;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  int unsigned  hold_cycles;

  strided_tensor_address_generator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .element_value_i  (element_value_i),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_address_o (target_address_o),
    .linear_index_o   (linear_index_o),
    .value_out_o      (value_out_o),
    .last_element_o   (last_element_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_walk();
    for (int l = 0; l < NUM_LANES; l++) walk_ctr[l] = '0;
    walk_index = '0;
  endfunction

  function automatic int unsigned active_dims();
    if (dim_count_q == 0) return 1;
    if (dim_count_q > NUM_LANES) return NUM_LANES;
    return int'(dim_count_q);
  endfunction

  // Zero extent behaves as extent one
  function automatic logic [LANE_W:0] lane_extent(int unsigned lane);
    logic [LANE_W-1:0] ext;
    ext = extents_q[lane*LANE_W +: LANE_W];
    return (ext == 0) ? (LANE_W+1)'(1) : {1'b0, ext};
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    case (idx)
      REG_DIM_COUNT:   dim_count_q   = data[DIM_COUNT_W-1:0];
      REG_BASE_OFFSET: base_offset_q = data[31:0];
      REG_EXTENTS:     extents_q     = data;
      REG_STRIDES:     strides_q     = data;
      REG_FILL_MODE:   fill_mode_q   = data[0];
      REG_FILL_VALUE:  fill_value_q  = data[31:0];
      default: ;
    endcase
  endfunction

  // Emit the current element of the walk, then advance the odometer
  function automatic walk_result_t predict_element(logic [31:0] elem_val, logic rst_walk);
    walk_result_t res;
    int unsigned  n;
    logic [31:0]  addr;
    logic         last;
    logic         carry;
    n = active_dims();
    if (rst_walk) clear_walk();
    addr = base_offset_q;
    last = 1'b1;
    for (int l = 0; l < n; l++) begin
      addr += 32'(walk_ctr[l]) * 32'(strides_q[l*LANE_W +: LANE_W]);
      if ({1'b0, walk_ctr[l]} < lane_extent(l) - 1) last = 1'b0;
    end
    res.address = addr;
    res.index   = walk_index;
    res.data    = fill_mode_q ? fill_value_q : elem_val;
    res.last    = last;
    if (last) begin
      clear_walk();
    end else begin
      walk_index  = walk_index + 32'd1;
      walk_ctr[0] = walk_ctr[0] + LANE_W'(1);
      carry = 1'b1;
      for (int l = 0; l + 1 < n; l++) begin
        if (carry) begin
          if ({1'b0, walk_ctr[l]} >= lane_extent(l)) begin
            walk_ctr[l]     = '0;
            walk_ctr[l + 1] = walk_ctr[l + 1] + LANE_W'(1);
          end else begin
            carry = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRS)
        $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
    end
  endfunction

  // Compare each result beat against the oldest expectation
  always @(posedge clk_i) begin
    walk_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_elements.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS)
          $display("unexpected result beat: address %h index %h", target_address_o,
                   linear_index_o);
      end else begin
        want = pending_elements.pop_front();
        check_field("target_address", want.address, target_address_o);
        check_field("linear_index", want.index, linear_index_o);
        check_field("value_out", want.data, value_out_o);
        check_field("last_element", 32'(want.last), 32'(last_element_o));
      end
    end
  end

  // Stall the result channel at random, or hold it for a requested stretch
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Abort when no beat moves on either channel for too long
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("timeout: no beat accepted in %0d cycles", STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one input beat after a random gap; hold it until accepted
  task automatic send_beat(input logic [31:0] elem_val, input logic rst_walk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= elem_val;
    restart_i       <= rst_walk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_elements.push_back(predict_element(elem_val, rst_walk));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves the write enable high so back-to-back writes need no toggle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Drain, then program the whole view; unused upper data bits carry junk
  task automatic set_view(input logic [2:0] dims, input logic [31:0] base,
                          input logic [63:0] ext, input logic [63:0] str,
                          input logic fmode, input logic [31:0] fval);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    drain();
    write_reg(REG_DIM_COUNT, {junk[63:3], dims});
    write_reg(REG_BASE_OFFSET, {junk[63:32], base});
    write_reg(REG_EXTENTS, ext);
    write_reg(REG_STRIDES, str);
    write_reg(REG_FILL_MODE, {junk[63:1], fmode});
    write_reg(REG_FILL_VALUE, {junk[31:0], fval});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_view();
    logic [2:0]  dims;
    logic [63:0] ext;
    dims = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    for (int l = 0; l < NUM_LANES; l++) begin
      case ($urandom_range(9))
        0:       ext[l*LANE_W +: LANE_W] = '0;
        1:       ext[l*LANE_W +: LANE_W] = '1;
        2:       ext[l*LANE_W +: LANE_W] = LANE_W'($urandom);
        default: ext[l*LANE_W +: LANE_W] = LANE_W'($urandom_range(5, 1));
      endcase
    end
    set_view(dims, $urandom, ext, {$urandom, $urandom}, ($urandom_range(3) == 0),
             $urandom);
  endtask

  // Registers at reset: one lane of extent one, so every beat is last
  task automatic test_reset_defaults();
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);
    send_beat($urandom, 1'b0);
  endtask

  // Out-of-range dim counts, zero extent, all-ones strides and address wrap
  task automatic test_dim_count_corners();
    set_view(3'd0, 32'hFFFF_FFFF, 64'h0003_0003_0003_0000, '1, 1'b0, '0);
    repeat (2) send_beat($urandom, 1'b0);
    set_view(3'd7, 32'hFFFF_FFF0, 64'h0002_0002_0001_0002, '1, 1'b0, '0);
    for (int i = 0; i < 11; i++) send_beat($urandom, (i == 5));
  endtask

  // Shrink extents mid-walk so counters sit at or past their extents
  task automatic test_shrink_midwalk();
    set_view(3'd3, 32'd100, 64'h0000_0004_0004_0004, 64'hFFFF_0100_0010_0001, 1'b0, '0);
    repeat (6) send_beat($urandom, 1'b0);
    drain();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    send_beat($urandom, 1'b0);
    set_view(3'd3, 32'd100, 64'h0000_0004_0004_0001, 64'hFFFF_0100_0010_0001, 1'b0, '0);
    repeat (3) send_beat($urandom, 1'b0);
  endtask

  task automatic test_fill_mode();
    set_view(3'd1, '0, 64'h0000_0000_0000_0003, 64'h0000_0000_0000_0007, 1'b1, '1);
    repeat (2) send_beat($urandom, 1'b0);
    set_view(3'd1, '0, 64'h0000_0000_0000_0003, 64'h0000_0000_0000_0007, 1'b1, '0);
    send_beat(32'hFFFF_FFFF, 1'b0);
  endtask

  // Random views and walks under each idling pattern
  task automatic test_random_walks(input int unsigned total);
    int unsigned sent;
    int unsigned seg;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 56; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      sent = 0;
      while (sent < total / 4) begin
        random_view();
        seg = $urandom_range(60, 8);
        repeat (seg) send_beat($urandom, ($urandom_range(99) < 3));
        sent += seg;
      end
    end
  endtask

  // Hold the result channel so the block fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_view(3'd2, $urandom, 64'h0000_0000_0005_0003, {$urandom, $urandom}, 1'b0, '0);
    @(posedge clk_i);
    hold_cycles = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (30) send_beat($urandom, 1'b0);
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_DIM_COUNT;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    element_value_i = '0;
    restart_i       = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_cycles     = 0;
    mismatches      = 0;
    dim_count_q     = DIM_COUNT_RST;
    base_offset_q   = '0;
    extents_q       = EXTENTS_RST;
    strides_q       = '0;
    fill_mode_q     = 1'b0;
    fill_value_q    = '0;
    clear_walk();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_dim_count_corners();
    test_shrink_midwalk();
    test_fill_mode();
    test_random_walks(1000);
    test_backpressure();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_elements.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== strided_tensor_address_generator.f =====
hw/rtl/stag_pkg.sv
hw/rtl/stag_walk.sv
hw/rtl/stag_addr.sv
hw/rtl/strided_tensor_address_generator.sv
dv/strided_tensor_address_generator_test.sv
